@@ rtl/lcrc_pkg.sv @@
`timescale 1ns / 1ps
package lcrc_pkg;

    localparam int CB = 16;
    localparam int QW = 2 * CB;
    localparam int EW = (QW + 3 > 36) ? QW + 3 : 36;
    localparam int PASSES = 4;
    localparam int PL = QW + 3;
    localparam int NS = 1 + PASSES * PL;

    localparam logic [3:0] LEFT   = 4'd1;
    localparam logic [3:0] RIGHT  = 4'd2;
    localparam logic [3:0] BOTTOM = 4'd4;
    localparam logic [3:0] TOP    = 4'd8;

    localparam logic [7:0] REG_LEFT   = 8'd0;
    localparam logic [7:0] REG_BOTTOM = 8'd1;
    localparam logic [7:0] REG_RIGHT  = 8'd2;
    localparam logic [7:0] REG_TOP    = 8'd3;

    localparam logic signed [CB-1:0] RST_LEFT   = CB'(0);
    localparam logic signed [CB-1:0] RST_BOTTOM = CB'(0);
    localparam logic signed [CB-1:0] RST_RIGHT  = CB'(499);
    localparam logic signed [CB-1:0] RST_TOP    = CB'(499);

    localparam logic [EW-1:0] QCAP = EW'(64'h4_0000_0000);
    localparam logic signed [EW:0] SMAX = (EW + 1)'((64'd1 << (CB - 1)) - 64'd1);
    localparam logic signed [EW:0] SMIN = -SMAX - (EW + 1)'(1);

    typedef struct packed {
        logic signed [CB-1:0] first_x;
        logic signed [CB-1:0] first_y;
        logic signed [CB-1:0] second_x;
        logic signed [CB-1:0] second_y;
    } seg_in_t;

    typedef struct packed {
        logic                 visible;
        logic signed [CB-1:0] clipped_first_x;
        logic signed [CB-1:0] clipped_first_y;
        logic signed [CB-1:0] clipped_second_x;
        logic signed [CB-1:0] clipped_second_y;
        logic [3:0]           first_region;
        logic [3:0]           second_region;
    } res_t;

    typedef struct packed {
        logic signed [CB-1:0] x0;
        logic signed [CB-1:0] y0;
        logic signed [CB-1:0] x1;
        logic signed [CB-1:0] y1;
        logic [3:0]           c0;
        logic [3:0]           c1;
        logic [3:0]           r0;
        logic [3:0]           r1;
        logic                 done;
        logic                 acc;
    } seg_t;

    typedef struct packed {
        logic                 work;
        logic                 mv1;
        logic                 ymv;
        logic                 neg;
        logic signed [CB-1:0] edge_v;
        logic signed [CB-1:0] base;
        logic [CB-1:0]        ua;
        logic [CB-1:0]        ub;
        logic [CB-1:0]        dvs;
        logic [QW-1:0]        num;
        logic [CB-1:0]        rem;
        logic [QW-1:0]        quo;
    } div_t;

    function automatic logic [3:0] region(
        input logic signed [CB-1:0] x,
        input logic signed [CB-1:0] y,
        input logic signed [CB-1:0] wl,
        input logic signed [CB-1:0] wb,
        input logic signed [CB-1:0] wr,
        input logic signed [CB-1:0] wt
    );
        logic [3:0] c;
        c = 4'd0;
        if (x < wl) c = c | LEFT;
        else if (x > wr) c = c | RIGHT;
        if (y < wb) c = c | BOTTOM;
        else if (y > wt) c = c | TOP;
        return c;
    endfunction

endpackage

@@ rtl/line_clip_region_codes.sv @@
`timescale 1ns / 1ps
// Cohen-Sutherland clipper for one segment against a window held in four registers.
//
// Input: a segment is accepted at a rising edge where start is high and busy is low.
// busy stays low, so one segment can be issued every cycle.
// Output: result_valid is high for one cycle with the result transaction. The
// receiver cannot stall, so the pipeline never holds and nothing is ever dropped.
// Configuration: cfg_valid with cfg_ready (always high) writes window register
// cfg_index (0 left, 1 bottom, 2 right, 3 top); other indexes are ignored. Write
// only while no segment is in flight.
// From the accepting edge to the strobe a segment passes one entry stage, four clip
// passes of 35 stages each and the output register. The result transaction is taken
// at the edge that ends the strobe cycle. Each pass spends one stage choosing the
// edge, one on the 16 by 16 multiply, 32 on a one-bit-per-stage restoring divider
// and one adding the quotient and recomputing the region code.
// Throughput is one segment per cycle.
// Reset clears all valid bits and loads the window to 0, 0, 499, 499.
module line_clip_region_codes (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lcrc_pkg::seg_in_t    seg,
    output logic                 result_valid,
    output lcrc_pkg::res_t       result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_index,
    input  logic [lcrc_pkg::CB-1:0] cfg_data
);

    localparam int CB = lcrc_pkg::CB;
    localparam int QW = lcrc_pkg::QW;
    localparam int EW = lcrc_pkg::EW;
    localparam int PL = lcrc_pkg::PL;
    localparam int NS = lcrc_pkg::NS;

    logic signed [CB-1:0] wl_reg, wb_reg, wr_reg, wt_reg;

    // Window registers. Writes are always taken.
    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= lcrc_pkg::RST_LEFT;
            wb_reg <= lcrc_pkg::RST_BOTTOM;
            wr_reg <= lcrc_pkg::RST_RIGHT;
            wt_reg <= lcrc_pkg::RST_TOP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lcrc_pkg::REG_LEFT:   wl_reg <= cfg_data;
                lcrc_pkg::REG_BOTTOM: wb_reg <= cfg_data;
                lcrc_pkg::REG_RIGHT:  wr_reg <= cfg_data;
                lcrc_pkg::REG_TOP:    wt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline: segment state and divider state travel with a valid bit.
    lcrc_pkg::seg_t seg_reg [0:NS-1];
    lcrc_pkg::div_t dv_reg  [0:NS-1];
    logic           vld_reg [0:NS-1];

    // Entry stage computes the original region codes.
    lcrc_pkg::seg_t seg_next0;
    always_comb
    begin
        seg_next0.x0   = seg.first_x;
        seg_next0.y0   = seg.first_y;
        seg_next0.x1   = seg.second_x;
        seg_next0.y1   = seg.second_y;
        seg_next0.c0   = lcrc_pkg::region(seg.first_x, seg.first_y,
                                          wl_reg, wb_reg, wr_reg, wt_reg);
        seg_next0.c1   = lcrc_pkg::region(seg.second_x, seg.second_y,
                                          wl_reg, wb_reg, wr_reg, wt_reg);
        seg_next0.r0   = seg_next0.c0;
        seg_next0.r1   = seg_next0.c1;
        seg_next0.done = 1'b0;
        seg_next0.acc  = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        seg_reg[0] <= seg_next0;
        dv_reg[0]  <= '0;
    end

    genvar g;
    generate
        for (g = 1; g < NS; g++)
        begin : g_stage
            localparam int K = (g - 1) % PL;
            lcrc_pkg::seg_t sp, sn;
            lcrc_pkg::div_t dp, dn;

            assign sp = seg_reg[g-1];
            assign dp = dv_reg[g-1];

            if (K == 0)
            begin : g_decide
                // Trivial accept or reject; otherwise choose endpoint and edge.
                logic [3:0]           co;
                logic signed [CB:0]   a, b, c;
                always_comb
                begin
                    sn = sp;
                    dn = dp;
                    dn.work = 1'b0;
                    co = (sp.c0 != 4'd0) ? sp.c0 : sp.c1;
                    if ((co & lcrc_pkg::TOP) != 4'd0)
                    begin
                        a = (CB + 1)'(sp.x1) - (CB + 1)'(sp.x0);
                        b = (CB + 1)'(wt_reg) - (CB + 1)'(sp.y0);
                        c = (CB + 1)'(sp.y1) - (CB + 1)'(sp.y0);
                        dn.base = sp.x0; dn.edge_v = wt_reg; dn.ymv = 1'b1;
                    end
                    else if ((co & lcrc_pkg::BOTTOM) != 4'd0)
                    begin
                        a = (CB + 1)'(sp.x1) - (CB + 1)'(sp.x0);
                        b = (CB + 1)'(wb_reg) - (CB + 1)'(sp.y0);
                        c = (CB + 1)'(sp.y1) - (CB + 1)'(sp.y0);
                        dn.base = sp.x0; dn.edge_v = wb_reg; dn.ymv = 1'b1;
                    end
                    else if ((co & lcrc_pkg::RIGHT) != 4'd0)
                    begin
                        a = (CB + 1)'(sp.y1) - (CB + 1)'(sp.y0);
                        b = (CB + 1)'(wr_reg) - (CB + 1)'(sp.x0);
                        c = (CB + 1)'(sp.x1) - (CB + 1)'(sp.x0);
                        dn.base = sp.y0; dn.edge_v = wr_reg; dn.ymv = 1'b0;
                    end
                    else
                    begin
                        a = (CB + 1)'(sp.y1) - (CB + 1)'(sp.y0);
                        b = (CB + 1)'(wl_reg) - (CB + 1)'(sp.x0);
                        c = (CB + 1)'(sp.x1) - (CB + 1)'(sp.x0);
                        dn.base = sp.y0; dn.edge_v = wl_reg; dn.ymv = 1'b0;
                    end
                    dn.neg = a[CB] ^ b[CB] ^ c[CB];
                    dn.ua  = CB'(a[CB] ? -a : a);
                    dn.ub  = CB'(b[CB] ? -b : b);
                    dn.dvs = CB'(c[CB] ? -c : c);
                    dn.mv1 = (sp.c0 == 4'd0);
                    dn.rem = '0;
                    dn.quo = '0;
                    if (!sp.done)
                    begin
                        if (sp.c0 == 4'd0 && sp.c1 == 4'd0)
                        begin
                            sn.done = 1'b1;
                            sn.acc  = 1'b1;
                        end
                        else if ((sp.c0 & sp.c1) != 4'd0)
                            sn.done = 1'b1;
                        else
                            dn.work = 1'b1;
                    end
                end
            end
            else if (K == 1)
            begin : g_mult
                always_comb
                begin
                    sn = sp;
                    dn = dp;
                    dn.num = QW'(dp.ua) * QW'(dp.ub);
                end
            end
            else if (K < PL - 1)
            begin : g_div
                // One quotient bit per stage, restoring.
                logic [CB:0] r;
                always_comb
                begin
                    sn = sp;
                    dn = dp;
                    r = {dp.rem, dp.num[QW-1]};
                    dn.num = {dp.num[QW-2:0], 1'b0};
                    if (r >= {1'b0, dp.dvs})
                    begin
                        r = r - {1'b0, dp.dvs};
                        dn.quo = {dp.quo[QW-2:0], 1'b1};
                    end
                    else
                        dn.quo = {dp.quo[QW-2:0], 1'b0};
                    dn.rem = CB'(r);
                end
            end
            else
            begin : g_update
                // Apply the quotient, saturate and recompute the moved code.
                logic [EW-1:0]        q;
                logic signed [EW:0]   s;
                logic signed [CB-1:0] v, nx, ny;
                always_comb
                begin
                    sn = sp;
                    dn = dp;
                    q = (dp.dvs == '0) ? '0 : EW'(dp.quo);
                    if (q > lcrc_pkg::QCAP) q = lcrc_pkg::QCAP;
                    s = dp.neg ? ((EW + 1)'(dp.base) - $signed({1'b0, q}))
                               : ((EW + 1)'(dp.base) + $signed({1'b0, q}));
                    if (s > lcrc_pkg::SMAX) v = CB'(lcrc_pkg::SMAX);
                    else if (s < lcrc_pkg::SMIN) v = CB'(lcrc_pkg::SMIN);
                    else v = CB'(s);
                    nx = dp.ymv ? v : dp.edge_v;
                    ny = dp.ymv ? dp.edge_v : v;
                    if (dp.work)
                    begin
                        if (dp.mv1)
                        begin
                            sn.x1 = nx; sn.y1 = ny;
                            sn.c1 = lcrc_pkg::region(nx, ny, wl_reg, wb_reg, wr_reg, wt_reg);
                        end
                        else
                        begin
                            sn.x0 = nx; sn.y0 = ny;
                            sn.c0 = lcrc_pkg::region(nx, ny, wl_reg, wb_reg, wr_reg, wt_reg);
                        end
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else
                    vld_reg[g] <= vld_reg[g-1];
            end

            always_ff @(posedge clk)
            begin
                seg_reg[g] <= sn;
                dv_reg[g]  <= dn;
            end
        end
    endgenerate

    // Output stage: the final accept test after the last pass.
    lcrc_pkg::seg_t sl;
    lcrc_pkg::res_t res_next;
    logic           acc;
    logic           res_valid_reg;
    lcrc_pkg::res_t res_reg;

    assign sl = seg_reg[NS-1];

    always_comb
    begin
        acc = sl.done ? sl.acc : (sl.c0 == 4'd0 && sl.c1 == 4'd0);
        res_next.visible          = acc;
        res_next.clipped_first_x  = acc ? sl.x0 : '0;
        res_next.clipped_first_y  = acc ? sl.y0 : '0;
        res_next.clipped_second_x = acc ? sl.x1 : '0;
        res_next.clipped_second_y = acc ? sl.y1 : '0;
        res_next.first_region     = sl.r0;
        res_next.second_region    = sl.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= vld_reg[NS-1];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

@@ tb/lcrc_checker.sv @@
`timescale 1ns / 1ps
module lcrc_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  lcrc_pkg::seg_in_t       seg,
    input  logic                    result_valid,
    input  lcrc_pkg::res_t          result,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [7:0]              cfg_index,
    input  logic [lcrc_pkg::CB-1:0] cfg_data,
    output int                      errors,
    output int                      outstanding
);

    localparam int     CB        = lcrc_pkg::CB;
    localparam longint COORD_MAX = 32767;
    localparam longint COORD_MIN = -32768;
    localparam longint QUOT_CAP  = 64'h4_0000_0000;

    longint         win_l, win_b, win_r, win_t;
    lcrc_pkg::res_t clip_queue[$];

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic logic [3:0] outcode(longint x, longint y);
        logic [3:0] c;
        c = 4'd0;
        if (x < win_l) c = c | lcrc_pkg::LEFT;
        else if (x > win_r) c = c | lcrc_pkg::RIGHT;
        if (y < win_b) c = c | lcrc_pkg::BOTTOM;
        else if (y > win_t) c = c | lcrc_pkg::TOP;
        return c;
    endfunction

    // base + a*b/c with the quotient truncated toward zero, then saturated.
    function automatic longint edge_point(longint base, longint a, longint b, longint c);
        logic   neg;
        longint q;
        if (c == 0) return clamp_coord(base);
        neg = ((a < 0) ^ (b < 0)) ^ (c < 0);
        q = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) / (c < 0 ? -c : c);
        if (q > QUOT_CAP) q = QUOT_CAP;
        return clamp_coord(neg ? base - q : base + q);
    endfunction

    function automatic lcrc_pkg::res_t clip_segment(lcrc_pkg::seg_in_t s);
        longint         x0, y0, x1, y1, nx, ny;
        logic [3:0]     c0, c1, co;
        logic           accept;
        lcrc_pkg::res_t r;
        x0 = s.first_x;
        y0 = s.first_y;
        x1 = s.second_x;
        y1 = s.second_y;
        c0 = outcode(x0, y0);
        c1 = outcode(x1, y1);
        r.first_region = c0;
        r.second_region = c1;
        accept = 1'b0;
        for (int pass = 0; pass <= lcrc_pkg::PASSES; pass++) begin
            if (c0 == 4'd0 && c1 == 4'd0) begin
                accept = 1'b1;
                break;
            end
            if ((c0 & c1) != 4'd0 || pass == lcrc_pkg::PASSES) break;
            co = (c0 != 4'd0) ? c0 : c1;
            if ((co & lcrc_pkg::TOP) != 4'd0) begin
                nx = edge_point(x0, x1 - x0, win_t - y0, y1 - y0);
                ny = win_t;
            end else if ((co & lcrc_pkg::BOTTOM) != 4'd0) begin
                nx = edge_point(x0, x1 - x0, win_b - y0, y1 - y0);
                ny = win_b;
            end else if ((co & lcrc_pkg::RIGHT) != 4'd0) begin
                ny = edge_point(y0, y1 - y0, win_r - x0, x1 - x0);
                nx = win_r;
            end else begin
                ny = edge_point(y0, y1 - y0, win_l - x0, x1 - x0);
                nx = win_l;
            end
            if (c0 != 4'd0) begin
                x0 = nx;
                y0 = ny;
                c0 = outcode(x0, y0);
            end else begin
                x1 = nx;
                y1 = ny;
                c1 = outcode(x1, y1);
            end
        end
        if (!accept) begin
            x0 = 0;
            y0 = 0;
            x1 = 0;
            y1 = 0;
        end
        r.visible = accept;
        r.clipped_first_x = CB'(x0);
        r.clipped_first_y = CB'(y0);
        r.clipped_second_x = CB'(x1);
        r.clipped_second_y = CB'(y1);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        lcrc_pkg::res_t exp_r;
        if (!rst_n) begin
            win_l = 0;
            win_b = 0;
            win_r = 499;
            win_t = 499;
            errors = 0;
            clip_queue.delete();
            outstanding = 0;
        end else begin
            if (result_valid) begin
                if (clip_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result %p", $realtime, result);
                end else begin
                    exp_r = clip_queue.pop_front();
                    if (result.visible !== exp_r.visible
                        || result.clipped_first_x !== exp_r.clipped_first_x
                        || result.clipped_first_y !== exp_r.clipped_first_y
                        || result.clipped_second_x !== exp_r.clipped_second_x
                        || result.clipped_second_y !== exp_r.clipped_second_y
                        || result.first_region !== exp_r.first_region
                        || result.second_region !== exp_r.second_region) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, exp_r, result);
                    end
                end
            end
            // A segment is predicted with the window in force when it is taken in.
            if (start && !busy)
                clip_queue.push_back(clip_segment(seg));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lcrc_pkg::REG_LEFT:   win_l = longint'($signed(cfg_data));
                    lcrc_pkg::REG_BOTTOM: win_b = longint'($signed(cfg_data));
                    lcrc_pkg::REG_RIGHT:  win_r = longint'($signed(cfg_data));
                    lcrc_pkg::REG_TOP:    win_t = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
            outstanding = clip_queue.size();
        end
    end
endmodule

@@ tb/tb_line_clip_region_codes.sv @@
`timescale 1ns / 1ps
module tb_line_clip_region_codes;
    // Stimulus and verdict for the line clipper. The checker beside the block
    // predicts every transaction and counts failures; this module drives and gives the verdict.

    localparam int CB = lcrc_pkg::CB;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    lcrc_pkg::seg_in_t seg;
    logic              result_valid;
    lcrc_pkg::res_t    result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [7:0]        cfg_index;
    logic [CB-1:0]     cfg_data;
    int                errors;
    int                outstanding;

    // Local copy of the window, used only to aim random segments near it.
    longint aim_l, aim_b, aim_r, aim_t;
    int     idle_pct;

    line_clip_region_codes uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .seg(seg),
        .result_valid(result_valid), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lcrc_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .seg(seg),
        .result_valid(result_valid), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the pipeline never drains.
    initial begin
        #2ms;
        $display("tb_line_clip_region_codes NOT OK");
        $finish;
    end

    // Offers one segment, idling at random first. Start stays high from one
    // transaction to the next unless an idle cycle falls between them. Busy is
    // sampled at the falling edge so the rising edge sees the same value.
    task automatic send_segment(input lcrc_pkg::seg_in_t s);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        seg <= s;
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    // Lowers start and holds off until every predicted result has come back.
    task automatic drain_pipeline;
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // cfg_valid is lowered after each write before the next can begin.
    task automatic write_reg(input logic [7:0] idx, input longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CB'(value);
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            lcrc_pkg::REG_LEFT:   aim_l = value;
            lcrc_pkg::REG_BOTTOM: aim_b = value;
            lcrc_pkg::REG_RIGHT:  aim_r = value;
            lcrc_pkg::REG_TOP:    aim_t = value;
            default: ;
        endcase
    endtask

    task automatic set_window(input longint l, input longint b, input longint r,
                              input longint t);
        write_reg(lcrc_pkg::REG_LEFT, l);
        write_reg(lcrc_pkg::REG_BOTTOM, b);
        write_reg(lcrc_pkg::REG_RIGHT, r);
        write_reg(lcrc_pkg::REG_TOP, t);
    endtask

    function automatic lcrc_pkg::seg_in_t make_seg(longint x0, longint y0, longint x1,
                                                   longint y1);
        lcrc_pkg::seg_in_t s;
        s.first_x = CB'(x0);
        s.first_y = CB'(y0);
        s.second_x = CB'(x1);
        s.second_y = CB'(y1);
        return s;
    endfunction

    // A coordinate spread around [lo, hi], so most endpoints fall inside or
    // just beside the window; the rest are drawn over the whole range.
    function automatic longint aimed_coord(longint lo, longint hi);
        longint span, v;
        if ($urandom_range(9) < 3) return longint'($signed(CB'($urandom)));
        span = (hi > lo ? hi - lo : lo - hi) + 8;
        v = (lo < hi ? lo : hi) - span + longint'($urandom_range(32'(3 * span)));
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    task automatic random_segments(input int count);
        for (int i = 0; i < count; i++)
            send_segment(make_seg(aimed_coord(aim_l, aim_r), aimed_coord(aim_b, aim_t),
                                  aimed_coord(aim_l, aim_r), aimed_coord(aim_b, aim_t)));
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        seg = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        aim_l = 0;
        aim_b = 0;
        aim_r = 499;
        aim_t = 499;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases on the reset window: trivial accept, trivial reject,
        // a clip on each edge, two-endpoint clips and the coordinate extremes.
        send_segment(make_seg(10, 10, 400, 300));
        send_segment(make_seg(0, 0, 499, 499));
        send_segment(make_seg(-50, -50, -10, 600));
        send_segment(make_seg(600, 10, 700, 400));
        send_segment(make_seg(250, 250, 250, 900));
        send_segment(make_seg(250, 250, 250, -900));
        send_segment(make_seg(250, 250, 900, 260));
        send_segment(make_seg(250, 250, -900, 240));
        send_segment(make_seg(-100, -100, 600, 600));
        send_segment(make_seg(-32768, -32768, 32767, 32767));
        send_segment(make_seg(32767, -32768, -32768, 32767));
        send_segment(make_seg(-32768, 250, 32767, 251));
        send_segment(make_seg(-600, 450, 100, 1200));
        send_segment(make_seg(-1, 500, 500, -1));
        send_segment(make_seg(32767, 32767, 32767, 32767));
        drain_pipeline();

        // Full-range window: saturation of intersections and edges at the extremes.
        set_window(-32768, -32768, 32767, 32767);
        send_segment(make_seg(-32768, 32767, 32767, -32768));
        send_segment(make_seg(-32768, -32768, -32768, -32768));
        drain_pipeline();
        set_window(32767, 32767, -32768, -32768);
        // An inverted window: every point is outside, exercising the pass limit.
        send_segment(make_seg(0, 0, 100, 50));
        send_segment(make_seg(-32768, 32767, 32767, -32768));
        send_segment(make_seg(40000 - 65536, 3, -7, 20000));
        drain_pipeline();
        // Writes to unused register indexes must leave the window alone.
        write_reg(8'd4, 123);
        write_reg(8'hFF, -1);
        set_window(-3, -2, 3, 2);
        send_segment(make_seg(-32768, -1, 32767, 1));
        send_segment(make_seg(-32768, 32767, 32767, -32768));
        drain_pipeline();

        // Random phases: no idling, heavy idling, light idling, each on its own
        // window, with a full drain between them before the window changes.
        set_window(0, 0, 499, 499);
        idle_pct = 0;
        random_segments(330);
        drain_pipeline();
        set_window(-200, -1000, 1500, 30);
        idle_pct = 71;
        random_segments(330);
        drain_pipeline();
        set_window(-32768, -32768, 32767, 32767);
        idle_pct = 9;
        random_segments(150);
        drain_pipeline();
        set_window(400, 300, -400, -300);
        idle_pct = 0;
        random_segments(150);
        drain_pipeline();
        set_window(longint'($signed(CB'($urandom))), longint'($signed(CB'($urandom))),
                   longint'($signed(CB'($urandom))), longint'($signed(CB'($urandom))));
        idle_pct = 71;
        random_segments(150);
        drain_pipeline();
        set_window(-32768, 100, -32000, 32767);
        idle_pct = 9;
        random_segments(150);

        // Let the last segments flow out, then look for stray strobes.
        start <= 1'b0;
        for (int n = 0; n < 5000 && outstanding != 0; n++) @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0 && outstanding == 0) begin
            $display("tb_line_clip_region_codes OK");
        end else begin
            $display("tb_line_clip_region_codes NOT OK");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/lcrc_pkg.sv
rtl/line_clip_region_codes.sv
tb/lcrc_checker.sv
tb/tb_line_clip_region_codes.sv
